FILE: design/kconv2d_pkg.sv
// shared types and constants for the 2d convolution block
// no dependencies

package kconv2d_pkg;

  localparam int unsigned MaxKernel = 5;
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned PixBits   = 16;
  localparam int unsigned CoefBits  = 12;
  localparam int unsigned ProdBits  = PixBits + 1 + CoefBits;
  localparam int unsigned RowBits   = ProdBits + 3;
  localparam int unsigned SumBits   = 33;
  localparam int unsigned AddrBits  = $clog2(MaxWidth);
  localparam int unsigned LineRows  = MaxKernel - 1;
  localparam int unsigned WordBits  = LineRows * PixBits;
  localparam int unsigned CfgBits   = MaxKernel * CoefBits;

  // configuration register indexes
  localparam logic [2:0] RegImageWidth   = 3'd0;
  localparam logic [2:0] RegKernelWidth  = 3'd1;
  localparam logic [2:0] RegKernelHeight = 3'd2;
  localparam logic [2:0] RegCoefRow0     = 3'd3;
  localparam logic [2:0] RegCoefRow1     = 3'd4;
  localparam logic [2:0] RegCoefRow2     = 3'd5;
  localparam logic [2:0] RegCoefRow3     = 3'd6;
  localparam logic [2:0] RegCoefRow4     = 3'd7;

  typedef logic [PixBits-1:0] pix_t;
  typedef logic signed [CoefBits-1:0] coef_t;
  typedef pix_t [MaxKernel-1:0][MaxKernel-1:0] window_t;
  typedef coef_t [MaxKernel-1:0][MaxKernel-1:0] coef_grid_t;

  typedef struct packed {
    logic vld;
    logic row_end;
  } tag_t;

endpackage

FILE: design/kconv2d_line_buf.sv
// line buffer: one word per column holding the last four image rows
// depends on kconv2d_pkg

module kconv2d_line_buf (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [kconv2d_pkg::AddrBits-1:0] rd_addr_i,
  input  logic                            wr_en_i,
  input  logic [kconv2d_pkg::AddrBits-1:0] wr_addr_i,
  input  logic [kconv2d_pkg::WordBits-1:0] wr_data_i,
  output logic [kconv2d_pkg::WordBits-1:0] rd_data_o
);

  logic [kconv2d_pkg::WordBits-1:0] mem_q [kconv2d_pkg::MaxWidth];
  logic [kconv2d_pkg::WordBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // a read of the column being written in the same cycle takes the new word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/kconv2d_mac.sv
// window multiply and adder tree: products, row sums, total
// depends on kconv2d_pkg

module kconv2d_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  kconv2d_pkg::tag_t                      tag_i,
  input  kconv2d_pkg::window_t                   win_i,
  input  kconv2d_pkg::coef_grid_t                coef_i,
  output kconv2d_pkg::tag_t                      tag_o,
  output logic signed [kconv2d_pkg::SumBits-1:0] sum_o
);

  localparam int unsigned K  = kconv2d_pkg::MaxKernel;
  localparam int unsigned PB = kconv2d_pkg::ProdBits;
  localparam int unsigned RB = kconv2d_pkg::RowBits;
  localparam int unsigned SB = kconv2d_pkg::SumBits;

  logic signed [PB-1:0] prod_d [K][K];
  logic signed [PB-1:0] prod_q [K][K];
  logic signed [RB-1:0] row_d [K];
  logic signed [RB-1:0] row_q [K];
  logic signed [SB-1:0] sum_d;
  logic signed [SB-1:0] sum_q;
  kconv2d_pkg::tag_t    prod_tag_q;
  kconv2d_pkg::tag_t    row_tag_q;
  kconv2d_pkg::tag_t    sum_tag_q;

  // a zero coefficient gives zero even where the window holds an unwritten pixel
  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        prod_d[i][j] = (coef_i[i][j] == '0) ? '0
                     : PB'($signed({1'b0, win_i[i][j]}) * coef_i[i][j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < K; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < K; j++) begin
        row_d[i] = row_d[i] + RB'(prod_q[i][j]);
      end
    end
  end

  // exact within the output range, so the top bits drop safely
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < K; i++) begin
      sum_d = sum_d + SB'(row_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_tag_q <= '0;
      row_tag_q  <= '0;
      sum_tag_q  <= '0;
    end else if (en_i) begin
      prod_tag_q <= tag_i;
      row_tag_q  <= prod_tag_q;
      sum_tag_q  <= row_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      row_q  <= row_d;
      sum_q  <= sum_d;
    end
  end

  assign tag_o = sum_tag_q;
  assign sum_o = sum_q;

endmodule

FILE: design/kernel_convolution_2d.sv
// top level of the 2d sliding-window convolution with line buffers
// depends on kconv2d_pkg, kconv2d_line_buf, kconv2d_mac
//
//   port group   dir  handshake               payload
//   in           in   in_valid_i/in_ready_o   pixel_i, frame_start_i
//   out          out  out_valid_o/out_ready_i filtered_value_o, row_end_o
//   cfg          in   cfg_we_i                cfg_index_i, cfg_value_i
//
// one pixel is taken per cycle while the pipeline is not stalled; a result is registered in turn
// after its pixel at the line buffer read, window shift, products, row sums and total
// the whole pipeline advances only while the output register is empty or taken
// reset clears the counters and the pipeline valid bits and sets the configuration to its defaults
// line buffer contents are not cleared; no clearing pass is run

module kernel_convolution_2d (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [15:0]                            pixel_i,
  input  logic                                   frame_start_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [32:0]                     filtered_value_o,
  output logic                                   row_end_o,
  input  logic                                   cfg_we_i,
  input  logic [2:0]                             cfg_index_i,
  input  logic [59:0]                            cfg_value_i
);

  localparam int unsigned K  = kconv2d_pkg::MaxKernel;
  localparam int unsigned AB = kconv2d_pkg::AddrBits;
  localparam int unsigned PB = kconv2d_pkg::PixBits;
  localparam int unsigned CB = kconv2d_pkg::CoefBits;

  logic [11:0] width_q;
  logic [2:0]  kw_q;
  logic [2:0]  kh_q;
  logic [kconv2d_pkg::CfgBits-1:0] coef_row_q [K];

  logic [11:0] w_eff;
  logic [2:0]  kw_eff;
  logic [2:0]  kh_eff;

  logic [AB-1:0] col_q, col_d, col_cur;
  logic [2:0]    row_q, row_d, row_cur;
  logic [11:0]   col_p1;
  logic          en, accept, emit;

  logic                      s1_vld_q;
  kconv2d_pkg::pix_t         s1_px_q;
  logic [AB-1:0]             s1_addr_q;
  kconv2d_pkg::tag_t         s1_tag_q;
  logic [kconv2d_pkg::WordBits-1:0] rd_word, wr_word;
  kconv2d_pkg::pix_t         column [K];

  kconv2d_pkg::window_t      window_q;
  kconv2d_pkg::tag_t         win_tag_q;
  kconv2d_pkg::coef_grid_t   coef_eff_d, coef_eff_q;
  kconv2d_pkg::tag_t         out_tag;
  logic [2:0]                off_r, off_c, kr, kc;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd2048;
      kw_q    <= 3'd3;
      kh_q    <= 3'd3;
      for (int i = 0; i < K; i++) coef_row_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kconv2d_pkg::RegImageWidth:   width_q <= cfg_value_i[11:0];
        kconv2d_pkg::RegKernelWidth:  kw_q    <= cfg_value_i[2:0];
        kconv2d_pkg::RegKernelHeight: kh_q    <= cfg_value_i[2:0];
        kconv2d_pkg::RegCoefRow0:     coef_row_q[0] <= cfg_value_i;
        kconv2d_pkg::RegCoefRow1:     coef_row_q[1] <= cfg_value_i;
        kconv2d_pkg::RegCoefRow2:     coef_row_q[2] <= cfg_value_i;
        kconv2d_pkg::RegCoefRow3:     coef_row_q[3] <= cfg_value_i;
        kconv2d_pkg::RegCoefRow4:     coef_row_q[4] <= cfg_value_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) w_eff = 12'd1;
    else if (width_q > 12'(kconv2d_pkg::MaxWidth)) w_eff = 12'(kconv2d_pkg::MaxWidth);
    else w_eff = width_q;
    if (kw_q == '0) kw_eff = 3'd1;
    else if (kw_q > 3'(K)) kw_eff = 3'(K);
    else kw_eff = kw_q;
    if (kh_q == '0) kh_eff = 3'd1;
    else if (kh_q > 3'(K)) kh_eff = 3'(K);
    else kh_eff = kh_q;
  end

  // kernel sits in the bottom-right corner of the window
  always_comb begin
    off_r = 3'(K) - kh_eff;
    off_c = 3'(K) - kw_eff;
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        kr = 3'(i) - off_r;
        kc = 3'(j) - off_c;
        if ((3'(i) >= off_r) && (3'(j) >= off_c)) begin
          coef_eff_d[i][j] = coef_row_q[kr][kc*CB +: CB];
        end else begin
          coef_eff_d[i][j] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    coef_eff_q <= coef_eff_d;
  end

  // position counters
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  always_comb begin
    row_cur = frame_start_i ? 3'd0 : row_q;
    if (frame_start_i || ({1'b0, col_q} >= w_eff)) col_cur = '0;
    else col_cur = col_q;
    col_p1 = {1'b0, col_cur} + 12'd1;
    emit   = ({1'b0, row_cur} + 4'd1 >= {1'b0, kh_eff}) && (col_p1 >= {9'd0, kw_eff});
    if (col_p1 >= w_eff) begin
      col_d = '0;
      row_d = (row_cur < 3'(K - 1)) ? row_cur + 3'd1 : row_cur;
    end else begin
      col_d = col_p1[AB-1:0];
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line buffer read returns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q          <= pixel_i;
      s1_addr_q        <= col_cur;
      s1_tag_q.vld     <= emit;
      s1_tag_q.row_end <= (col_p1 == w_eff);
    end
  end

  kconv2d_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_cur),
    .wr_en_i   (en && s1_vld_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  // oldest row first, new pixel last
  always_comb begin
    for (int r = 0; r < K - 1; r++) column[r] = rd_word[r*PB +: PB];
    column[K-1] = s1_px_q;
    wr_word = {s1_px_q, rd_word[kconv2d_pkg::WordBits-1:PB]};
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_vld_q) begin
      for (int r = 0; r < K; r++) begin
        for (int m = 0; m < K - 1; m++) window_q[r][m] <= window_q[r][m+1];
        window_q[r][K-1] <= column[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_tag_q <= '0;
    end else if (en) begin
      win_tag_q.vld     <= s1_vld_q && s1_tag_q.vld;
      win_tag_q.row_end <= s1_tag_q.row_end;
    end
  end

  kconv2d_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (win_tag_q),
    .win_i  (window_q),
    .coef_i (coef_eff_q),
    .tag_o  (out_tag),
    .sum_o  (filtered_value_o)
  );

  assign out_valid_o = out_tag.vld;
  assign row_end_o   = out_tag.row_end;

  // checks
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= 3'(K - 1))
    else $error("row count beyond kernel rows");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame_start_i && !cfg_we_i |=>
      (col_q == AB'(1) && row_q == 3'd0) || (col_q == '0 && row_q == 3'd1))
    else $error("counters not restarted at frame start");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame_start_i && ((kh_eff > 3'd1) || (kw_eff > 3'd1)) |=>
      !s1_tag_q.vld)
    else $error("result flagged on first pixel of a frame");

endmodule

FILE: tb/kconv2d_checker.sv
// checker for the 2d convolution block: watches the pixel and result channels,
// predicts each filtered value from its own line buffers, window and kernel copy
// depends on kconv2d_pkg

module kconv2d_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [15:0]       pixel_i,
  input  logic              frame_start_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic signed [32:0] filtered_value_i,
  input  logic              row_end_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [59:0]       cfg_value_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [32:0] value;
    logic               row_end;
  } filt_result_t;

  logic [11:0] width_q;
  logic [2:0]  kw_q, kh_q;
  logic [59:0] coef_q [kconv2d_pkg::MaxKernel];
  kconv2d_pkg::pix_t lines_q [kconv2d_pkg::LineRows][kconv2d_pkg::MaxWidth];
  kconv2d_pkg::pix_t win_q [kconv2d_pkg::MaxKernel][kconv2d_pkg::MaxKernel];
  int unsigned col_q, row_q;
  filt_result_t expected_q [$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [63:0] coef_of(int unsigned r, int unsigned c);
    logic signed [kconv2d_pkg::CoefBits-1:0] raw;
    raw = coef_q[r][c*kconv2d_pkg::CoefBits +: kconv2d_pkg::CoefBits];
    return 64'(raw);
  endfunction

  task automatic take_pixel(input kconv2d_pkg::pix_t px, input logic fs);
    int unsigned w, kw, kh, c;
    kconv2d_pkg::pix_t col [kconv2d_pkg::MaxKernel];
    logic signed [63:0] acc;
    filt_result_t res;
    w  = clamp_size(width_q, kconv2d_pkg::MaxWidth);
    kw = clamp_size(kw_q, kconv2d_pkg::MaxKernel);
    kh = clamp_size(kh_q, kconv2d_pkg::MaxKernel);
    if (fs) begin
      col_q = 0;
      row_q = 0;
    end
    if (col_q >= w) col_q = 0;
    c = col_q;
    for (int r = 0; r < kconv2d_pkg::LineRows; r++) col[r] = lines_q[r][c];
    col[kconv2d_pkg::MaxKernel-1] = px;
    for (int r = 0; r < kconv2d_pkg::LineRows; r++) lines_q[r][c] = col[r+1];
    for (int r = 0; r < kconv2d_pkg::MaxKernel; r++) begin
      for (int m = 0; m < kconv2d_pkg::MaxKernel-1; m++) win_q[r][m] = win_q[r][m+1];
      win_q[r][kconv2d_pkg::MaxKernel-1] = col[r];
    end
    if (row_q + 1 >= kh && col_q + 1 >= kw) begin
      acc = 0;
      for (int k = 0; k < kh; k++)
        for (int m = 0; m < kw; m++)
          acc += $signed({48'd0, win_q[kconv2d_pkg::MaxKernel-kh+k]
                                      [kconv2d_pkg::MaxKernel-kw+m]}) * coef_of(k, m);
      res.value   = acc[32:0];
      res.row_end = (col_q + 1 == w);
      expected_q.insert(expected_q.size(), res);
    end
    if (col_q + 1 >= w) begin
      col_q = 0;
      if (row_q + 1 < kconv2d_pkg::MaxKernel) row_q++;
    end else begin
      col_q++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filt_result_t exp_r;
    if (!rst_ni) begin
      width_q = 12'd2048;
      kw_q = 3'd3;
      kh_q = 3'd3;
      for (int r = 0; r < kconv2d_pkg::MaxKernel; r++) coef_q[r] = '0;
      for (int r = 0; r < kconv2d_pkg::MaxKernel; r++)
        for (int m = 0; m < kconv2d_pkg::MaxKernel; m++) win_q[r][m] = '0;
      col_q = 0;
      row_q = 0;
      expected_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %0d row_end %0b",
                                    filtered_value_i, row_end_i);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.value !== filtered_value_i || exp_r.row_end !== row_end_i) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected %0d/%0b got %0d/%0b", exp_r.value,
                       exp_r.row_end, filtered_value_i, row_end_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          kconv2d_pkg::RegImageWidth:   width_q = cfg_value_i[11:0];
          kconv2d_pkg::RegKernelWidth:  kw_q = cfg_value_i[2:0];
          kconv2d_pkg::RegKernelHeight: kh_q = cfg_value_i[2:0];
          default: coef_q[cfg_index_i - kconv2d_pkg::RegCoefRow0] = cfg_value_i;
        endcase
      end
      if (in_valid_i && in_ready_i) take_pixel(pixel_i, frame_start_i);
    end
  end

endmodule

FILE: tb/tb.sv
// testbench top for kernel_convolution_2d: random frames with bursty pixels,
// a stalling receiver and kernel/width changes between frames
// depends on kconv2d_pkg, kconv2d_checker and the block itself

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [15:0] pixel_i = '0;
  logic frame_start_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [32:0] filtered_value_o;
  logic row_end_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [59:0] cfg_value_i = '0;
  int fail_count, pending;
  int pixels_sent;

  always #10 clk_i = ~clk_i;

  kernel_convolution_2d u_dut (.*);

  kconv2d_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .pixel_i, .frame_start_i,
    .out_valid_i(out_valid_o), .out_ready_i, .filtered_value_i(filtered_value_o),
    .row_end_i(row_end_o), .cfg_we_i, .cfg_index_i, .cfg_value_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: stall pattern of its own, sometimes always ready
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk_i);
        out_ready_i <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) >= mode - 1);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_value_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(input logic [15:0] px, input logic fs);
    in_valid_i    <= 1'b1;
    pixel_i       <= px;
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
  endtask

  function automatic logic [15:0] rand_pixel(input int mode);
    case (mode)
      0: return 16'hffff;
      1: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // coefficient rows: extremes or random
  function automatic logic [59:0] coef_row(input int mode);
    logic [59:0] v;
    for (int c = 0; c < kconv2d_pkg::MaxKernel; c++)
      case (mode)
        0: v[c*kconv2d_pkg::CoefBits +: kconv2d_pkg::CoefBits] = 12'h800;
        1: v[c*kconv2d_pkg::CoefBits +: kconv2d_pkg::CoefBits] = 12'h7ff;
        default: v[c*kconv2d_pkg::CoefBits +: kconv2d_pkg::CoefBits] = 12'($urandom);
      endcase
    return v;
  endfunction

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic run_frame(input int w, input int rows, input int pmode,
                           input bit no_fs);
    int burst;
    burst = 0;
    for (int i = 0; i < w * rows; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
      burst--;
      send_pixel(rand_pixel(pmode == 3 ? $urandom_range(0, 9) : pmode),
                 (i == 0) && !no_fs);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic setup(input int w, input int kw, input int kh, input int cmode);
    write_reg(kconv2d_pkg::RegImageWidth, 60'(w));
    write_reg(kconv2d_pkg::RegKernelWidth, 60'(kw));
    write_reg(kconv2d_pkg::RegKernelHeight, 60'(kh));
    write_reg(kconv2d_pkg::RegCoefRow0, coef_row(cmode));
    write_reg(kconv2d_pkg::RegCoefRow1, coef_row(cmode));
    write_reg(kconv2d_pkg::RegCoefRow2, coef_row(cmode));
    write_reg(kconv2d_pkg::RegCoefRow3, coef_row(cmode));
    write_reg(kconv2d_pkg::RegCoefRow4, coef_row(cmode));
  endtask

  initial begin
    int w, kw, kh;
    pixels_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extreme pixels against extreme coefficients at 5x5, then a random 1x1
    setup(5, 5, 5, 0);
    run_frame(5, 5, 0, 0);
    drain();
    setup(5, 5, 5, 1);
    run_frame(5, 5, 0, 0);
    drain();
    setup(3, 1, 1, 2);
    run_frame(3, 2, 3, 0);
    drain();
    // width below kernel gives no results
    setup(2, 3, 3, 2);
    run_frame(2, 4, 3, 0);
    drain();
    // random frames, mostly small; odd kernels
    while (pixels_sent < 1000) begin
      kw = 2 * $urandom_range(0, 2) + 1;
      kh = 2 * $urandom_range(0, 2) + 1;
      w  = ($urandom_range(0, 30) == 0) ? 40 : $urandom_range(kw, 24);
      setup(w, kw, kh, $urandom_range(0, 6));
      run_frame(w, $urandom_range(kh, kh + 4),
                $urandom_range(0, 12) > 1 ? 3 : $urandom_range(0, 1), 0);
      // stream continuing without frame start
      if ($urandom_range(0, 4) == 0) run_frame(w, $urandom_range(1, 3), 3, 1);
      drain();
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
